FILE: sv/kway_merge_min_heap_unit_macros.svh
// Assertion macros for the k-way merge heap unit.
`ifndef KWAY_MERGE_MIN_HEAP_UNIT_MACROS_SVH
`define KWAY_MERGE_MIN_HEAP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define KMH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define KMH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KMH_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KMH_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/kmh_pkg.sv
// Shared types and constants of the k-way merge heap unit.
package kmh_pkg;
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int KEY_W    = 63;
    localparam int SRC_W    = 8;
    localparam int IDX_W    = 16;
    localparam int ENT_W    = KEY_W + SRC_W + IDX_W;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_POP    = 2'd1;
    localparam logic [1:0] FUNC_FEED   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NO_FEED = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [SRC_W-1:0] src;
        logic [IDX_W-1:0] idx;
    } t_entry;

    // datapath commands, one per cycle
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_RD_PARENT, OP_UP_CMP, OP_UP_LAST,
        OP_RD_ROOT, OP_RD_LAST, OP_DN_START, OP_RD_LEFT, OP_RD_RIGHT,
        OP_DN_CMP, OP_DN_LAST
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic do_up;     // accepted word climbs the heap
        logic do_pop;    // accepted word removes the root
        logic at_root;   // moving slot is the root
        logic up_stop;   // parent already ranks first
        logic leaf;      // moving slot has no children
        logic dn_stop;   // moving entry ranks no later than any child it has
        logic [CNT_W-1:0] count;
    } t_stat;

    function automatic logic entry_less(input t_entry a, input t_entry b);
        return {a.key, a.src, a.idx} < {b.key, b.src, b.idx};
    endfunction
endpackage

FILE: sv/kmh_ram.sv
// Generic single-port RAM with registered read.
module kmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: sv/kmh_datapath.sv
// Heap datapath: entry memory, position registers and comparisons.
module kmh_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kmh_pkg::t_cmd     i_cmd,
    input  logic [1:0]        i_func,
    input  logic [7:0]        i_source,
    input  logic [15:0]       i_peak_index,
    input  logic [62:0]       i_key,
    output kmh_pkg::t_stat    o_stat,
    output logic [1:0]        o_status,
    output logic [7:0]        o_out_source,
    output logic [15:0]       o_out_peak_index,
    output logic [62:0]       o_out_key
);
    import kmh_pkg::*;
`include "kway_merge_min_heap_unit_macros.svh"

    logic [CNT_W-1:0] r_count;
    logic [ADDR_W-1:0] r_pos, r_best;
    logic [SRC_W-1:0] r_pend_src;
    logic [IDX_W-1:0] r_pend_idx;
    logic r_pend_valid;
    t_entry r_cur, r_best_e, r_out;
    logic r_do_up, r_do_pop;
    logic [1:0] r_status;

    logic we;
    logic [ADDR_W-1:0] addr;
    t_entry wdata, rdata;

    kmh_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    logic [ADDR_W-1:0] parent, left_c, right_c;
    logic [CNT_W-1:0] pos_w, left_w, right_w;
    assign parent  = (r_pos - ADDR_W'(1)) >> 1;
    assign pos_w   = CNT_W'(r_pos);
    assign left_w  = (pos_w << 1) + CNT_W'(1);
    assign right_w = left_w + CNT_W'(1);
    assign left_c  = left_w[ADDR_W-1:0];
    assign right_c = right_w[ADDR_W-1:0];

    logic full;
    assign full = (r_count == CNT_W'(CAPACITY));

    logic up_stop, dn_right_ok, dn_stop;
    logic [ADDR_W-1:0] fin_best;
    t_entry fin_best_e;

    // rdata holds the parent during an up-compare and the right child during a down-compare
    assign up_stop     = !entry_less(r_cur, rdata);
    assign dn_right_ok = right_w < r_count;

    always_comb begin
        fin_best = r_best;
        fin_best_e = r_best_e;
        if (dn_right_ok && entry_less(rdata, r_best_e)) begin
            fin_best = right_c;
            fin_best_e = rdata;
        end
    end

    assign dn_stop = !entry_less(fin_best_e, r_cur);

    // decode the accepted word
    logic [1:0] ld_status;
    logic ld_up, ld_pop;
    t_entry ld_e;
    always_comb begin
        ld_status = ST_OK;
        ld_up = 1'b0;
        ld_pop = 1'b0;
        ld_e = '{key: i_key, src: i_source, idx: i_peak_index};
        case (i_func)
            FUNC_INSERT: begin
                if (full) begin
                    ld_status = ST_FULL;
                end else begin
                    ld_up = 1'b1;
                end
            end
            FUNC_FEED: begin
                ld_e.src = r_pend_src;
                ld_e.idx = r_pend_idx;
                if (!r_pend_valid) begin
                    ld_status = ST_NO_FEED;
                end else if (full) begin
                    ld_status = ST_FULL;
                end else begin
                    ld_up = 1'b1;
                end
            end
            FUNC_POP: begin
                if (r_count == '0) begin
                    ld_status = ST_EMPTY;
                end else begin
                    ld_pop = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // The moving entry r_cur is written only at its final slot;
    // entries that trade places with it are written at the slot it leaves.
    always_comb begin
        we = 1'b0;
        addr = r_pos;
        wdata = r_cur;
        case (i_cmd.op)
            OP_RD_PARENT: addr = parent;
            OP_UP_CMP: begin
                we = 1'b1;
                wdata = up_stop ? r_cur : rdata;
            end
            OP_UP_LAST: we = 1'b1;
            OP_RD_ROOT: addr = '0;
            OP_RD_LAST: addr = r_count[ADDR_W-1:0];
            OP_RD_LEFT: addr = left_c;
            OP_RD_RIGHT: addr = right_c;
            OP_DN_CMP: begin
                we = 1'b1;
                wdata = dn_stop ? r_cur : fin_best_e;
            end
            OP_DN_LAST: we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend_valid <= 1'b0;
            r_pend_src <= '0;
            r_pend_idx <= '0;
            r_status <= ST_OK;
            r_out <= '0;
            r_cur <= '0;
            r_best_e <= '0;
            r_pos <= '0;
            r_best <= '0;
            r_do_up <= 1'b0;
            r_do_pop <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_status <= ld_status;
                    r_out <= '0;
                    r_cur <= ld_e;
                    r_pos <= r_count[ADDR_W-1:0];
                    r_do_up <= ld_up;
                    r_do_pop <= ld_pop;
                    if (ld_up) begin
                        r_count <= r_count + CNT_W'(1);
                    end else if (ld_pop) begin
                        r_count <= r_count - CNT_W'(1);
                    end
                    if (ld_up && i_func == FUNC_FEED) begin
                        r_pend_valid <= 1'b0;
                    end
                end
                OP_UP_CMP: begin
                    if (!up_stop) r_pos <= parent;
                end
                OP_RD_LAST: begin
                    // root arrives now
                    r_out <= rdata;
                    r_pend_src <= rdata.src;
                    r_pend_idx <= rdata.idx + IDX_W'(1);
                    r_pend_valid <= 1'b1;
                end
                OP_DN_START: begin
                    // last entry arrives now; start it at the root
                    r_cur <= rdata;
                    r_pos <= '0;
                end
                OP_RD_RIGHT: begin
                    r_best <= left_c;
                    r_best_e <= rdata;
                end
                OP_DN_CMP: begin
                    if (!dn_stop) r_pos <= fin_best;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.do_up = r_do_up;
    assign o_stat.do_pop = r_do_pop;
    assign o_stat.at_root = (r_pos == '0);
    assign o_stat.up_stop = up_stop;
    assign o_stat.leaf = !(left_w < r_count);
    assign o_stat.dn_stop = dn_stop;
    assign o_stat.count = r_count;
    assign o_status = r_status;
    assign o_out_source = r_out.src;
    assign o_out_peak_index = r_out.idx;
    assign o_out_key = r_out.key;

    `KMH_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `KMH_ASSERT_NXT(a_pop_sets_pend, i_clk, i_rst_n, i_cmd.op == OP_RD_LAST, r_pend_valid)
    `KMH_ASSERT_IMP(a_up_in_range, i_clk, i_rst_n, i_cmd.op == OP_UP_CMP, CNT_W'(r_pos) < r_count)
    `KMH_ASSERT_IMP(a_dn_in_range, i_clk, i_rst_n, i_cmd.op == OP_DN_CMP, CNT_W'(r_pos) < r_count)
endmodule

FILE: sv/kmh_ctrl.sv
// Heap controller: sequences insert, pop and feed operations.
module kmh_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  kmh_pkg::t_stat i_stat,
    output kmh_pkg::t_cmd  o_cmd
);
    import kmh_pkg::*;
`include "kway_merge_min_heap_unit_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_UP, S_UP_CMP, S_RD_ROOT, S_RD_LAST,
        S_DN_START, S_DN, S_DN_RIGHT, S_DN_CMP, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic r_valid;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                // load the word at the accepting edge
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.do_up) begin
                    n_state = S_UP;
                end else if (i_stat.do_pop) begin
                    n_state = S_RD_ROOT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_UP: begin
                if (i_stat.at_root) begin
                    o_cmd.op = OP_UP_LAST;
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = OP_RD_PARENT;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                o_cmd.op = OP_UP_CMP;
                n_state = i_stat.up_stop ? S_OUT : S_UP;
            end
            S_RD_ROOT: begin
                o_cmd.op = OP_RD_ROOT;
                n_state = S_RD_LAST;
            end
            S_RD_LAST: begin
                o_cmd.op = OP_RD_LAST;
                n_state = S_DN_START;
            end
            S_DN_START: begin
                o_cmd.op = OP_DN_START;
                n_state = (i_stat.count == '0) ? S_OUT : S_DN;
            end
            S_DN: begin
                if (i_stat.leaf) begin
                    o_cmd.op = OP_DN_LAST;
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = OP_RD_LEFT;
                    n_state = S_DN_RIGHT;
                end
            end
            S_DN_RIGHT: begin
                o_cmd.op = OP_RD_RIGHT;
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                o_cmd.op = OP_DN_CMP;
                n_state = i_stat.dn_stop ? S_OUT : S_DN;
            end
            S_OUT: begin
                // hold the result word until taken
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (n_state == S_OUT);
        end
    end

    `KMH_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, !r_valid)
    `KMH_ASSERT_NXT(a_accept_load, i_clk, i_rst_n, i_valid && o_ready, r_state == S_CHECK)
    `KMH_ASSERT_IMP(a_valid_out, i_clk, i_rst_n, r_valid, r_state == S_OUT)
    `KMH_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_valid && !i_ready, r_valid)
endmodule

FILE: sv/kway_merge_min_heap_unit.sv
// Top level of the k-way merge min-heap unit.
// Binary min-heap of (source, peak index, key) entries, 256 deep.
// Input channel i_valid/o_ready carries one word: func, source, peak_index, key.
// func insert adds an entry, pop removes the smallest (key, then source,
// then index) and records source and index+1 for a later feed, feed inserts
// the next key of that recorded source.
// Output channel o_valid/i_ready returns one word per input word: status,
// popped entry fields (zero unless a pop succeeds), count and is_empty.
// One word is worked at a time. o_valid rises once the word is done: a flagged
// or unused func goes straight to the result, insert and feed first climb the
// heap level by level and pop first descends it level by level, each level
// paced by reads and a write of the one-port entry memory. o_ready returns the
// cycle after the result is taken.
// Reset empties the heap and clears the pending feed; the entry memory is not
// cleared, only slots below the count are used.
// While the receiver stalls the result holds and no new word is taken.
module kway_merge_min_heap_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_source,
    input  logic [15:0] i_peak_index,
    input  logic [62:0] i_key,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_out_source,
    output logic [15:0] o_out_peak_index,
    output logic [62:0] o_out_key,
    output logic [8:0]  o_count,
    output logic        o_is_empty
);
    import kmh_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    kmh_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .i_stat(stat), .o_cmd(cmd)
    );

    kmh_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_func(i_func),
        .i_source(i_source), .i_peak_index(i_peak_index), .i_key(i_key),
        .o_stat(stat), .o_status(o_status), .o_out_source(o_out_source),
        .o_out_peak_index(o_out_peak_index), .o_out_key(o_out_key)
    );

    assign o_count    = 9'(stat.count);
    assign o_is_empty = (stat.count == '0);
endmodule

FILE: tb/sv/kway_merge_min_heap_unit_tb.sv
// Self-checking testbench for the k-way merge min-heap unit: directed table, fill and drain, then random traffic.
`timescale 1ns / 1ps

module kway_merge_min_heap_unit_tb;
    import kmh_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM       = 770;
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam logic [62:0] KEY_MAX = {63{1'b1}};

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  src;
        logic [15:0] idx;
        logic [62:0] key;
    } t_word_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  src;
        logic [15:0] idx;
        logic [62:0] key;
        logic [8:0]  count;
        logic        empty;
    } t_word_out;

    typedef struct {
        t_word_in  w;
        bit        typed;
        t_word_out res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_func = '0;
    logic [7:0]  i_source = '0;
    logic [15:0] i_peak_index = '0;
    logic [62:0] i_key = '0;
    logic        i_ready = 1'b0;
    logic        o_ready, o_valid, o_is_empty;
    logic [1:0]  o_status;
    logic [7:0]  o_out_source;
    logic [15:0] o_out_peak_index;
    logic [62:0] o_out_key;
    logic [8:0]  o_count;

    kway_merge_min_heap_unit dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    t_entry    mirror_heap[CAPACITY];
    int        mirror_count;
    logic [7:0]  feed_src;
    logic [15:0] feed_idx;
    bit          feed_ok;

    t_word_out expected_words[$];
    t_word_out typed_words[$];
    bit        typed_flags[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  drain_hold;
    bit  done_sending;

    function automatic bit ranks_above(t_entry a, t_entry b);
        if (a.key != b.key) return a.key < b.key;
        if (a.src != b.src) return a.src < b.src;
        return a.idx < b.idx;
    endfunction

    function automatic logic [1:0] heap_push(t_entry e);
        int pos;
        t_entry t;
        if (mirror_count >= CAPACITY) return ST_FULL;
        pos = mirror_count;
        mirror_heap[pos] = e;
        mirror_count++;
        while (pos > 0 && ranks_above(mirror_heap[pos], mirror_heap[(pos - 1) / 2])) begin
            t = mirror_heap[pos];
            mirror_heap[pos] = mirror_heap[(pos - 1) / 2];
            mirror_heap[(pos - 1) / 2] = t;
            pos = (pos - 1) / 2;
        end
        return ST_OK;
    endfunction

    function automatic void heap_drop_root();
        int pos, l, r, best;
        t_entry t;
        pos = 0;
        mirror_count--;
        if (mirror_count == 0) return;
        mirror_heap[0] = mirror_heap[mirror_count];
        forever begin
            l = 2 * pos + 1;
            r = l + 1;
            best = pos;
            if (l < mirror_count && ranks_above(mirror_heap[l], mirror_heap[best])) best = l;
            if (r < mirror_count && ranks_above(mirror_heap[r], mirror_heap[best])) best = r;
            if (best == pos) break;
            t = mirror_heap[pos];
            mirror_heap[pos] = mirror_heap[best];
            mirror_heap[best] = t;
            pos = best;
        end
    endfunction

    function automatic t_word_out merge_step(t_word_in w);
        t_word_out r;
        t_entry e;
        r = '0;
        case (w.func)
            FUNC_INSERT: begin
                e.key = w.key; e.src = w.src; e.idx = w.idx;
                r.status = heap_push(e);
            end
            FUNC_POP: begin
                if (mirror_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.src = mirror_heap[0].src;
                    r.idx = mirror_heap[0].idx;
                    r.key = mirror_heap[0].key;
                    feed_src = mirror_heap[0].src;
                    feed_idx = mirror_heap[0].idx + 16'd1;
                    feed_ok = 1'b1;
                    heap_drop_root();
                end
            end
            FUNC_FEED: begin
                if (!feed_ok) begin
                    r.status = ST_NO_FEED;
                end else begin
                    e.key = w.key; e.src = feed_src; e.idx = feed_idx;
                    r.status = heap_push(e);
                    if (r.status == ST_OK) feed_ok = 1'b0;
                end
            end
            default: ;
        endcase
        r.count = mirror_count[8:0];
        r.empty = (mirror_count == 0);
        return r;
    endfunction

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // send one word; predict at acceptance
    task automatic send_word(t_word_in w, bit typed, t_word_out res);
        i_valid      <= 1'b1;
        i_func       <= w.func;
        i_source     <= w.src;
        i_peak_index <= w.idx;
        i_key        <= w.key;
        do @(posedge i_clk); while (!o_ready);
        expected_words.push_back(merge_step(w));
        typed_flags.push_back(typed);
        typed_words.push_back(res);
    endtask

    task automatic send_gapped(t_word_in w, bit typed, t_word_out res);
        int gap;
        gap = short_or_long_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        send_word(w, typed, res);
    endtask

    function automatic t_word_in mk(logic [1:0] f, logic [7:0] s, logic [15:0] x,
                                    logic [62:0] k);
        t_word_in w;
        w.func = f; w.src = s; w.idx = x; w.key = k;
        return w;
    endfunction

    function automatic logic [62:0] rand_key();
        logic [62:0] k;
        case ($urandom_range(0, 3))
            0: k = 63'($urandom_range(0, 7));
            1: k = 63'({$urandom, $urandom});
            2: k = KEY_MAX - 63'($urandom_range(0, 3));
            default: k = {31'($urandom_range(0, 1)), $urandom};
        endcase
        return k;
    endfunction

    // receiver: random stalls, one long hold-off
    initial begin : receiver
        int gap;
        bit long_done;
        long_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!long_done && expected_words.size() > 0) begin
                long_done = 1'b1;
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            gap = short_or_long_gap();
            if (drain_hold) gap = 0;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    // checker
    always @(posedge i_clk) begin
        t_word_out act, exp;
        bit typed;
        t_word_out res;
        if (i_rst_n && o_valid && i_ready) begin
            act.status = o_status; act.src = o_out_source; act.idx = o_out_peak_index;
            act.key = o_out_key; act.count = o_count; act.empty = o_is_empty;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, act);
                errors++;
            end else begin
                exp = expected_words.pop_front();
                typed = typed_flags.pop_front();
                res = typed_words.pop_front();
                if (typed && res != exp) begin
                    $display("%0t: table row expects %h, predictor %h", $time, res, exp);
                    errors++;
                end
                if (act.status != exp.status) begin
                    $display("%0t: status exp %0d act %0d", $time, exp.status, act.status);
                    errors++;
                end
                if (act.src != exp.src) begin
                    $display("%0t: source exp %0d act %0d", $time, exp.src, act.src);
                    errors++;
                end
                if (act.idx != exp.idx) begin
                    $display("%0t: peak index exp %0d act %0d", $time, exp.idx, act.idx);
                    errors++;
                end
                if (act.key != exp.key) begin
                    $display("%0t: key exp %h act %h", $time, exp.key, act.key);
                    errors++;
                end
                if (act.count != exp.count) begin
                    $display("%0t: count exp %0d act %0d", $time, exp.count, act.count);
                    errors++;
                end
                if (act.empty != exp.empty) begin
                    $display("%0t: empty exp %0d act %0d", $time, exp.empty, act.empty);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (!done_sending || expected_words.size() != 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic t_word_out res_of(logic [1:0] st, int cnt);
        t_word_out r;
        r = '0;
        r.status = st; r.count = cnt[8:0]; r.empty = (cnt == 0);
        return r;
    endfunction

    initial begin : stimulus
        t_row table_rows[$];
        t_row row;
        t_word_in w;
        int n, sel;
        t_word_out none;
        none = '0;
        drain_hold = 1'b0;
        done_sending = 1'b0;
        mirror_count = 0;
        feed_src = '0;
        feed_idx = '0;
        feed_ok = 1'b0;

        // directed table; typed results only where obvious
        row.typed = 1; row.w = mk(FUNC_POP, 8'hFF, 16'hFFFF, KEY_MAX);
        row.res = res_of(ST_EMPTY, 0); table_rows.push_back(row);
        row.w = mk(FUNC_FEED, 8'h00, 16'h0000, 63'd5);
        row.res = res_of(ST_NO_FEED, 0); table_rows.push_back(row);
        row.w = mk(FUNC_SPARE, 8'hAA, 16'h5555, 63'd1);
        row.res = res_of(ST_OK, 0); table_rows.push_back(row);
        row.w = mk(FUNC_INSERT, 8'hFF, 16'hFFFF, KEY_MAX);
        row.res = res_of(ST_OK, 1); table_rows.push_back(row);
        row.typed = 0;
        row.w = mk(FUNC_INSERT, 8'h00, 16'h0000, 63'd0); table_rows.push_back(row);
        row.w = mk(FUNC_INSERT, 8'h03, 16'h0007, 63'd100); table_rows.push_back(row);
        row.w = mk(FUNC_INSERT, 8'h01, 16'h0009, 63'd100); table_rows.push_back(row);
        row.w = mk(FUNC_INSERT, 8'h01, 16'h0002, 63'd100); table_rows.push_back(row);
        row.w = mk(FUNC_POP, 0, 0, 0); table_rows.push_back(row);
        row.w = mk(FUNC_FEED, 8'h55, 16'h1234, 63'd50); table_rows.push_back(row);
        row.w = mk(FUNC_FEED, 0, 0, 63'd1);
        row.typed = 1; row.res = res_of(ST_NO_FEED, 5); table_rows.push_back(row);
        row.typed = 0;
        row.w = mk(FUNC_POP, 0, 0, 0); table_rows.push_back(row);
        row.w = mk(FUNC_POP, 0, 0, 0); table_rows.push_back(row);
        row.w = mk(FUNC_POP, 0, 0, 0); table_rows.push_back(row);
        row.w = mk(FUNC_POP, 0, 0, 0); table_rows.push_back(row);
        row.w = mk(FUNC_INSERT, 8'h10, 16'hFFFF, 63'd2); table_rows.push_back(row);
        row.w = mk(FUNC_POP, 0, 0, 0); table_rows.push_back(row);   // index wraps on feed
        row.w = mk(FUNC_FEED, 0, 0, 63'd3); table_rows.push_back(row);
        row.w = mk(FUNC_POP, 0, 0, 0); table_rows.push_back(row);
        row.w = mk(FUNC_POP, 0, 0, 0); table_rows.push_back(row);
        row.w = mk(FUNC_POP, 0, 0, 0); table_rows.push_back(row);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[k]) send_gapped(table_rows[k].w, table_rows[k].typed,
                                            table_rows[k].res);

        // fill to capacity, then overflow on insert and feed
        i_valid <= 1'b0;
        wait (expected_words.size() == 0);
        while (mirror_count < CAPACITY)
            send_word(mk(FUNC_INSERT, 8'($urandom), 16'($urandom), rand_key()), 0, none);
        send_word(mk(FUNC_INSERT, 8'h7E, 16'h0001, 63'd9), 1, res_of(ST_FULL, CAPACITY));
        send_word(mk(FUNC_POP, 0, 0, 0), 0, none);
        send_word(mk(FUNC_INSERT, 8'h01, 16'h0001, 63'd9), 0, none);
        send_word(mk(FUNC_FEED, 0, 0, 63'd9), 1, res_of(ST_FULL, CAPACITY));
        // drain fully
        while (mirror_count > 0) send_gapped(mk(FUNC_POP, 0, 0, 0), 0, none);
        send_word(mk(FUNC_FEED, 0, 0, 63'd4), 0, none);

        // random: merge-like traffic with some noise
        n = 0;
        while (n < N_RANDOM) begin
            sel = $urandom_range(0, 99);
            if (n == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                wait (expected_words.size() == 0);
            end
            if (sel < 30 && mirror_count < CAPACITY - 2)
                w = mk(FUNC_INSERT, 8'($urandom), 16'($urandom), rand_key());
            else if (sel < 62)
                w = mk(FUNC_POP, 8'($urandom), 16'($urandom), rand_key());
            else if (sel < 92)
                w = mk(FUNC_FEED, 8'($urandom), 16'($urandom), rand_key());
            else if (sel < 97)
                w = mk(FUNC_INSERT, 8'($urandom), 16'($urandom), rand_key());
            else
                w = mk(FUNC_SPARE, 8'($urandom), 16'($urandom), rand_key());
            if (w.func != FUNC_SPARE) n++;
            send_gapped(w, 0, none);
        end

        i_valid <= 1'b0;
        done_sending = 1'b1;
        drain_hold = 1'b1;
        wait (expected_words.size() == 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+sv
sv/kmh_pkg.sv
sv/kmh_ram.sv
sv/kmh_datapath.sv
sv/kmh_ctrl.sv
sv/kway_merge_min_heap_unit.sv
tb/sv/kway_merge_min_heap_unit_tb.sv
